// ----- hw/rtl/maccormack_scalar_correct_limit_macros.svh -----
// Assertion helpers used by the queue RTL file of the corrector.
`ifndef MACCORMACK_SCALAR_CORRECT_LIMIT_MACROS_SVH
`define MACCORMACK_SCALAR_CORRECT_LIMIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MCL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define MCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mcl_pkg;

  // Configuration register layout.
  localparam int CfgWidthBits  = 11;
  localparam int CfgHeightBits = 13;
  localparam int CfgIndexBits  = 1;
  localparam int CfgDataBits   = 13;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgGridWidth  = 1'b0,
    CfgGridHeight = 1'b1
  } cfg_reg_e;

  // Grid geometry limits.
  localparam int RowBits  = 12;
  localparam int RowLimit = 4096;

  // Defaults for the top-level parameters.
  localparam int MaxWidthDef   = 1024;
  localparam int SampleBitsDef = 24;
  localparam int BorderDef     = 2;

  // Depth of the queue between the window front end and the limiter.
  localparam int QueueDepth = 4;

endpackage

`default_nettype wire

// ----- hw/rtl/mcl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcl_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int BORDER      = 2,
  parameter int ENTRY_BITS  = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mcl_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [mcl_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]         prev_i,
  input  wire logic [SAMPLE_BITS-1:0]         fwd_i,
  input  wire logic [SAMPLE_BITS-1:0]         bwd_i,
  input  wire logic                           q_full_i,
  output logic                                push_o,
  output logic [ENTRY_BITS-1:0]               entry_o
);
  import mcl_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // Compare width for column arithmetic, holds MAX_WIDTH plus the border.
  localparam int WW  = (ColW + 1 > CfgWidthBits) ? ColW + 1 : CfgWidthBits;
  localparam int RW  = CfgHeightBits;

  // Configuration and raster position.
  logic [CfgWidthBits-1:0]  width_q;
  logic [CfgHeightBits-1:0] height_q;
  logic [ColW-1:0]          col_q, col_d;
  logic [RowBits-1:0]       row_q, row_d;

  // Stage register between acceptance and the window arithmetic.
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_prod_q;
  logic                     s1_last_q;
  logic [RowBits-1:0]       s1_row_q;
  logic [ColW-1:0]          s1_col_q;
  logic [SB-1:0]            s1_prev_q;

  // Row store: backward, forward, prev packed per column.
  logic [3*SB-1:0]          store_mem [MAX_WIDTH];
  logic [3*SB-1:0]          rd_q;

  // Left neighbors of the 2x2 window.
  logic signed [SB-1:0]     lpc_q, lpa_q, lfa_q, lba_q;

  logic                     in_fire;
  logic                     s1_adv;
  logic [WW-1:0]            w_eff, c_ext;
  logic [RW-1:0]            h_eff, r_ext;
  logic                     prod, last;

  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_adv     = s1_valid_q && (!s1_prod_q || !q_full_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_adv);
  assign push_o     = s1_adv && s1_prod_q;

  // Clamp the configured size into the supported range.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (height_q > RW'(RowLimit)) begin
      h_eff = RW'(RowLimit);
    end else begin
      h_eff = height_q;
    end
  end

  // Classify the arriving cell: its window closes the block one row up and left.
  always_comb begin
    c_ext = WW'(col_q);
    r_ext = RW'(row_q);
    prod  = (c_ext >= WW'(BORDER + 1)) && (c_ext + WW'(BORDER) <= w_eff) &&
            (r_ext >= RW'(BORDER + 1)) && (r_ext + RW'(BORDER) <= h_eff);
    last  = (c_ext + WW'(BORDER) == w_eff) && (r_ext + RW'(BORDER) == h_eff);
  end

  // Raster counters step once per accepted beat.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (c_ext + WW'(1) >= w_eff) begin
      col_d = '0;
      row_d = (RW'(r_ext + RW'(1)) >= h_eff) ? '0 : RowBits'(r_ext + RW'(1));
    end else begin
      col_d = ColW'(c_ext + WW'(1));
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= CfgWidthBits'(1024);
      height_q   <= CfgHeightBits'(1024);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_prod_q  <= 1'b0;
      lpc_q      <= '0;
      lpa_q      <= '0;
      lfa_q      <= '0;
      lba_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CfgGridWidth:  width_q  <= cfg_wdata_i[CfgWidthBits-1:0];
          CfgGridHeight: height_q <= cfg_wdata_i[CfgHeightBits-1:0];
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_fire) begin
        s1_prod_q <= prod;
      end
      if (s1_adv) begin
        lpa_q <= rd_q[SB-1:0];
        lfa_q <= rd_q[2*SB-1:SB];
        lba_q <= rd_q[3*SB-1:2*SB];
        lpc_q <= s1_prev_q;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q <= last;
      s1_row_q  <= RowBits'(row_q - RowBits'(1));
      s1_col_q  <= ColW'(col_q - ColW'(1));
      s1_prev_q <= prev_i;
    end
  end

  // Row store: read the old row entry and replace it in the same beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q             <= store_mem[col_q];
      store_mem[col_q] <= {bwd_i, fwd_i, prev_i};
    end
  end

  // Window arithmetic: limits over the 2x2 block and the corrected sum.
  logic signed [SB-1:0] ap, p, lo1, hi1, lo2, hi2, lo, hi;
  logic signed [SB:0]   diff, half, sum;

  always_comb begin
    ap   = rd_q[SB-1:0];
    p    = s1_prev_q;
    lo1  = (ap < lpa_q) ? ap : lpa_q;
    hi1  = (ap > lpa_q) ? ap : lpa_q;
    lo2  = (p < lpc_q) ? p : lpc_q;
    hi2  = (p > lpc_q) ? p : lpc_q;
    lo   = (lo1 < lo2) ? lo1 : lo2;
    hi   = (hi1 > hi2) ? hi1 : hi2;
    diff = {lpa_q[SB-1], lpa_q} - {lba_q[SB-1], lba_q};
    half = diff >>> 1;
    sum  = {lfa_q[SB-1], lfa_q} + half;
  end

  assign entry_o = ENTRY_BITS'({s1_last_q, s1_col_q, s1_row_q, lfa_q, hi, lo, sum});

endmodule

`default_nettype wire

// ----- hw/rtl/mcl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcl_queue #(
  parameter int ENTRY_BITS = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [ENTRY_BITS-1:0] entry_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output logic [ENTRY_BITS-1:0]      entry_o
);
  import mcl_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [ENTRY_BITS-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

`include "maccormack_scalar_correct_limit_macros.svh"

  `MCL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(QueueDepth), "queue count overrun")
  `MCL_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o), "push into a full queue")
  `MCL_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o, "pop from an empty queue")
  `MCL_ASSERT_IMP(a_ptr_match, clk_i, rst_ni, count_q == '0 || full_o, wr_ptr_q == rd_ptr_q, "queue pointers disagree with count")

endmodule

`default_nettype wire

// ----- hw/rtl/mcl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcl_back #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int ENTRY_BITS  = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  wire logic [ENTRY_BITS-1:0] q_entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [SAMPLE_BITS-1:0]     corrected_o,
  output logic                       reverted_o,
  output logic [mcl_pkg::RowBits-1:0] cell_row_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cell_col_o,
  output logic                       last_cell_o
);
  import mcl_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int ColW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SumLo  = 0;
  localparam int LoLo   = SumLo + SB + 1;
  localparam int HiLo   = LoLo + SB;
  localparam int FwdLo  = HiLo + SB;
  localparam int RowLo  = FwdLo + SB;
  localparam int ColLo  = RowLo + RowBits;
  localparam int LastLo = ColLo + ColW;

  logic signed [SB:0]   sum;
  logic signed [SB-1:0] lo, hi, fwd;
  logic                 rev;

  logic                 out_valid_q;
  logic [SB-1:0]        corrected_q;
  logic                 reverted_q;
  logic [RowBits-1:0]   row_q;
  logic [ColW-1:0]      col_q;
  logic                 last_q;

  // Limiter: fall back to the forward value when the sum leaves the block range.
  always_comb begin
    sum = q_entry_i[LoLo-1:SumLo];
    lo  = q_entry_i[HiLo-1:LoLo];
    hi  = q_entry_i[FwdLo-1:HiLo];
    fwd = q_entry_i[RowLo-1:FwdLo];
    rev = (sum > $signed({hi[SB-1], hi})) || (sum < $signed({lo[SB-1], lo}));
  end

  // The output register frees up whenever it is empty or its beat is taken.
  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign corrected_o = corrected_q;
  assign reverted_o  = reverted_q;
  assign cell_row_o  = row_q;
  assign cell_col_o  = col_q;
  assign last_cell_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      corrected_q <= rev ? fwd : sum[SB-1:0];
      reverted_q  <= rev;
      row_q       <= q_entry_i[ColLo-1:RowLo];
      col_q       <= q_entry_i[LastLo-1:ColLo];
      last_q      <= q_entry_i[LastLo];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/maccormack_scalar_correct_limit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// MacCormack corrector with a min/max limiter for a 2-D scalar grid. Cells
// enter in raster order, one per beat, carrying the value before advection,
// the forward result and the backward result. The block accepts one cell per
// clock while the queue has room and returns one result beat per interior
// cell (BORDER cells in from every edge), tagged with its row and column. A
// result waits for the cell one row and one column further on, which completes
// its 2x2 window, and then passes the stage register and the queue into the
// output register. The rate is set by the single-port row store, read and
// written once per beat at the current column. Writing either size register
// restarts the grid at row 0, column 0; write only while the block is idle.
// The row store is not cleared at reset and needs no clearing time.
module maccormack_scalar_correct_limit #(
  parameter int MAX_WIDTH   = mcl_pkg::MaxWidthDef,
  parameter int SAMPLE_BITS = mcl_pkg::SampleBitsDef,
  parameter int BORDER      = mcl_pkg::BorderDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [mcl_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [mcl_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  // Input stream.
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata from bit 0: prev_value, forward_value, backward_value, zero fill
  input  wire logic [(3*SAMPLE_BITS+7)/8*8-1:0] s_axis_tdata_i,
  // Output stream.
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // tdata from bit 0: corrected_value, cell_row, cell_col, zero fill
  output logic [(SAMPLE_BITS + mcl_pkg::RowBits +
                 ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1) + 7)/8*8-1:0] m_axis_tdata_o,
  // tuser: reverted
  output logic                                  m_axis_tuser_o,
  // tlast: last_cell
  output logic                                  m_axis_tlast_o
);
  import mcl_pkg::*;

  localparam int SB       = SAMPLE_BITS;
  localparam int ColW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EntryW   = (SB + 1) + 3 * SB + RowBits + ColW + 1;
  localparam int OutDataW = (SB + RowBits + ColW + 7) / 8 * 8;

  logic              q_full, push, q_valid, pop;
  logic [EntryW-1:0] push_entry, head_entry;
  logic [SB-1:0]     corrected;
  logic [RowBits-1:0] cell_row;
  logic [ColW-1:0]   cell_col;

  // Front end: raster tracking, row store and window arithmetic.
  mcl_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .BORDER     (BORDER),
    .ENTRY_BITS (EntryW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .prev_i     (s_axis_tdata_i[SB-1:0]),
    .fwd_i      (s_axis_tdata_i[2*SB-1:SB]),
    .bwd_i      (s_axis_tdata_i[3*SB-1:2*SB]),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Decoupling queue of pending interior cells.
  mcl_queue #(
    .ENTRY_BITS(EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  // Back end: limiter decision and output register.
  mcl_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .ENTRY_BITS (EntryW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (head_entry),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .corrected_o(corrected),
    .reverted_o (m_axis_tuser_o),
    .cell_row_o (cell_row),
    .cell_col_o (cell_col),
    .last_cell_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutDataW'({cell_col, cell_row, corrected});

endmodule

`default_nettype wire
